// ----- design/voxel_color_pooling_table_unit_assert.svh -----
// ----------------------------------------------------------------------------
// voxel color pooling table: assertion macros
// Implication and next-cycle checks, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VOXEL_COLOR_POOLING_TABLE_UNIT_ASSERT_SVH
`define VOXEL_COLOR_POOLING_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define VCP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
// next-cycle implication
`define VCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define VCP_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define VCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- design/vcp_pkg.sv -----
// ----------------------------------------------------------------------------
// vcp_pkg
// Shared types, codes and constants of the voxel color pooling table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vcp_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;
  localparam int DEFAULT_INDEX_BITS  = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COORD_W    = 32;
  localparam int COLOR_W    = 8;
  localparam int SUM_W      = 24;
  localparam int COUNT_W    = 16;
  localparam int CELL_W     = 16;
  localparam int PROD_W     = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_RANGE     = 3'd2,
    ST_SATURATED = 3'd3,
    ST_READ      = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_CLEARED   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    POOL_AVG  = 3'd0,
    POOL_MIN  = 3'd1,
    POOL_MAX  = 3'd2,
    POOL_SUM  = 3'd3,
    POOL_ZERO = 3'd4
  } pool_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X       = 3'd0,
    REG_ORIGIN_Y       = 3'd1,
    REG_ORIGIN_Z       = 3'd2,
    REG_INV_CELL_SIZE  = 3'd3,
    REG_POOL_MODE      = 3'd4,
    REG_COLORS_PRESENT = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL,
    S_FIX,
    S_RANGE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_UPD_HIT,
    S_UPD_NEW,
    S_RD_CHK,
    S_RD_WAIT,
    S_DIVIDE,
    S_DONE
  } ctrl_state_e;

  // per-voxel payload held next to the key (channel 0 red, 1 green, 2 blue)
  typedef struct packed {
    logic [COUNT_W-1:0]          count;
    logic [2:0][SUM_W-1:0]       sum;
    logic [2:0][COLOR_W-1:0]     minc;
    logic [2:0][COLOR_W-1:0]     maxc;
  } entry_t;

  typedef struct packed {
    status_e                     status;
    logic [2:0][CELL_W-1:0]      grid_idx;
    logic [2:0][SUM_W-1:0]       color;
    logic [COUNT_W-1:0]          count;
    logic                        last_cell;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    mul;
    logic    fix;
    logic    srch_start;
    logic    mem_rd_srch;
    logic    addr_inc;
    logic    mem_rd_cur;
    logic    write_hit;
    logic    write_new;
    logic    div_start;
    logic    clear;
    logic    res_set;
    status_e res_status;
    logic    res_hit;
    logic    out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       axis_last;
    logic       oor;
    logic       srch_end;
    logic       key_match;
    logic       count_sat;
    logic       table_full;
    logic       cur_empty;
    logic       need_div;
    logic       div_done;
    logic       out_free;
  } dp_stat_t;

endpackage

// ----- design/vcp_divider.sv -----
// ----------------------------------------------------------------------------
// vcp_divider
// Three-lane restoring divider, one quotient bit per lane per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vcp_divider import vcp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [2:0][SUM_W-1:0]   dividend_i,
  input  logic [COUNT_W-1:0]      divisor_i,
  output logic [2:0][SUM_W-1:0]   quot_o,
  output logic                    done_o
);

  localparam int StepW = $clog2(SUM_W);

  logic                    busy_q;
  logic                    done_q;
  logic [StepW-1:0]        step_q;
  logic [2:0][SUM_W-1:0]   dvd_q, dvd_d;
  logic [2:0][COUNT_W:0]   rem_q, rem_d;
  logic [COUNT_W-1:0]      dsr_q;

  // one restoring step per lane
  always_comb begin
    logic [COUNT_W:0] trial;
    for (int c = 0; c < 3; c++) begin
      trial = {rem_q[c][COUNT_W-1:0], dvd_q[c][SUM_W-1]};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d[c] = trial - {1'b0, dsr_q};
        dvd_d[c] = {dvd_q[c][SUM_W-2:0], 1'b1};
      end else begin
        rem_d[c] = trial;
        dvd_d[c] = {dvd_q[c][SUM_W-2:0], 1'b0};
      end
    end
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o = dvd_q;
  assign done_o = done_q;

endmodule

// ----- design/vcp_datapath.sv -----
// ----------------------------------------------------------------------------
// vcp_datapath
// Config registers, index arithmetic, voxel memory, result and output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "voxel_color_pooling_table_unit_assert.svh"

module vcp_datapath import vcp_pkg::*; #(
  parameter int TableDepth = DEFAULT_TABLE_DEPTH,
  parameter int IndexBits  = DEFAULT_INDEX_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic [1:0]                   action_i,
  input  logic [2:0][COORD_W-1:0]      pos_i,
  input  logic [2:0][COLOR_W-1:0]      rgb_i,
  input  ctrl_cmd_t                    cmd_i,
  output dp_stat_t                     stat_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output result_t                      out_o
);

  localparam int AddrW = $clog2(TableDepth);
  localparam int UsedW = $clog2(TableDepth + 1);
  localparam int KeyW  = 3 * IndexBits;
  localparam int EntW  = $bits(entry_t);
  localparam int MemW  = KeyW + EntW;
  localparam int ValW  = COORD_W + 2;

  // configuration registers
  logic [2:0][COORD_W-1:0] origin_q;
  logic [COORD_W-1:0]      inv_q;
  logic [2:0]              mode_q;
  logic                    colors_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      inv_q    <= COORD_W'(65536);
      mode_q   <= POOL_AVG;
      colors_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ORIGIN_X:       origin_q[0] <= cfg_data_i;
        REG_ORIGIN_Y:       origin_q[1] <= cfg_data_i;
        REG_ORIGIN_Z:       origin_q[2] <= cfg_data_i;
        REG_INV_CELL_SIZE:  inv_q       <= cfg_data_i;
        REG_POOL_MODE:      mode_q      <= cfg_data_i[2:0];
        REG_COLORS_PRESENT: colors_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // captured transaction
  logic [1:0]              action_q;
  logic [2:0][COORD_W-1:0] pos_q;
  logic [2:0][COLOR_W-1:0] rgb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      action_q <= action_i;
      pos_q    <= pos_i;
      rgb_q    <= rgb_i;
    end
  end

  // offset magnitude times inverse cell size, one axis per pass
  logic [1:0]          axis_q;
  logic [COORD_W:0]    diff, mag_w;
  logic [COORD_W-1:0]  mag;
  logic [PROD_W-1:0]   prod_w, prod_q;
  logic                neg_q;

  always_comb begin
    diff   = {pos_q[axis_q][COORD_W-1], pos_q[axis_q]}
           - {origin_q[axis_q][COORD_W-1], origin_q[axis_q]};
    mag_w  = diff[COORD_W] ? (~diff + (COORD_W+1)'(1)) : diff;
    mag    = mag_w[COORD_W-1:0];
    prod_w = mag * inv_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_w;
      neg_q  <= diff[COORD_W];
    end
  end

  // floor of the product over 2^32, then range check
  logic [ValW-1:0]              hi_w, val_w;
  logic [ValW-IndexBits:0]      val_top;
  logic                         in_rng;
  logic [2:0][IndexBits-1:0]    idx_q;
  logic                         oor_q;

  always_comb begin
    hi_w    = {2'b00, prod_q[PROD_W-1:COORD_W]};
    val_w   = neg_q ? (ValW'(0) - (hi_w + ValW'(|prod_q[COORD_W-1:0]))) : hi_w;
    val_top = val_w[ValW-1:IndexBits-1];
    in_rng  = (&val_top) | ~(|val_top);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= '0;
      oor_q  <= 1'b0;
    end else if (cmd_i.load_in) begin
      axis_q <= '0;
      oor_q  <= 1'b0;
    end else if (cmd_i.fix) begin
      axis_q <= axis_q + 2'd1;
      oor_q  <= oor_q | ~in_rng;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fix) begin
      idx_q[axis_q] <= val_w[IndexBits-1:0];
    end
  end

  // table pointers
  logic [UsedW-1:0] used_q, cursor_q, addr_q;
  logic             read_done;

  assign read_done = cmd_i.res_set && (cmd_i.res_status == ST_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      cursor_q <= '0;
      addr_q   <= '0;
    end else begin
      if (cmd_i.clear) begin
        used_q   <= '0;
        cursor_q <= '0;
      end else begin
        if (cmd_i.write_new) used_q <= used_q + UsedW'(1);
        if (read_done)       cursor_q <= cursor_q + UsedW'(1);
      end
      if (cmd_i.srch_start)    addr_q <= '0;
      else if (cmd_i.addr_inc) addr_q <= addr_q + UsedW'(1);
    end
  end

  // voxel memory: key and payload side by side
  logic [MemW-1:0]  mem [TableDepth];
  logic [MemW-1:0]  rd_q, wdata;
  logic [KeyW-1:0]  key_cur, rd_key;
  entry_t           rd_ent, upd_ent, new_ent;
  logic [AddrW-1:0] raddr;

  assign key_cur = {idx_q[0], idx_q[1], idx_q[2]};
  assign rd_key  = rd_q[MemW-1 -: KeyW];
  assign rd_ent  = entry_t'(rd_q[EntW-1:0]);
  assign raddr   = cmd_i.mem_rd_cur ? cursor_q[AddrW-1:0] : addr_q[AddrW-1:0];

  // merge of the point into an entry, and a fresh entry
  always_comb begin
    upd_ent       = rd_ent;
    upd_ent.count = rd_ent.count + COUNT_W'(1);
    new_ent.count = COUNT_W'(1);
    for (int c = 0; c < 3; c++) begin
      upd_ent.sum[c]  = rd_ent.sum[c] + SUM_W'(rgb_q[c]);
      upd_ent.minc[c] = (rd_ent.minc[c] < rgb_q[c]) ? rd_ent.minc[c] : rgb_q[c];
      upd_ent.maxc[c] = (rd_ent.maxc[c] > rgb_q[c]) ? rd_ent.maxc[c] : rgb_q[c];
      new_ent.sum[c]  = SUM_W'(rgb_q[c]);
      new_ent.minc[c] = rgb_q[c];
      new_ent.maxc[c] = rgb_q[c];
    end
    wdata = cmd_i.write_hit ? {key_cur, upd_ent} : {key_cur, new_ent};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_hit || cmd_i.write_new) begin
      mem[addr_q[AddrW-1:0]] <= wdata;
    end
    if (cmd_i.mem_rd_srch || cmd_i.mem_rd_cur) begin
      rd_q <= mem[raddr];
    end
  end

  // averaging divider
  logic [2:0][SUM_W-1:0] quot;
  logic                  div_done;

  vcp_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rd_ent.sum),
    .divisor_i  (rd_ent.count),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  // cell indices sign-extended or cut to the output width
  logic [2:0][IndexBits-1:0] rd_idx;
  logic [2:0][CELL_W-1:0]    add_cell, rd_cell;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign rd_idx[a] = rd_key[(2-a)*IndexBits +: IndexBits];
    for (genvar b = 0; b < CELL_W; b++) begin : g_bit
      if (b < IndexBits) begin : g_in
        assign add_cell[a][b] = idx_q[a][b];
        assign rd_cell[a][b]  = rd_idx[a][b];
      end else begin : g_ext
        assign add_cell[a][b] = idx_q[a][IndexBits-1];
        assign rd_cell[a][b]  = rd_idx[a][IndexBits-1];
      end
    end
  end

  // result staging
  result_t res_q, res_d;

  always_comb begin
    res_d        = '0;
    res_d.status = cmd_i.res_status;
    case (cmd_i.res_status)
      ST_ADDED: begin
        res_d.grid_idx = add_cell;
        res_d.count    = cmd_i.res_hit ? upd_ent.count : COUNT_W'(1);
      end
      ST_FULL: begin
        res_d.grid_idx = add_cell;
      end
      ST_SATURATED: begin
        res_d.grid_idx = add_cell;
        res_d.count    = COUNT_MAX;
      end
      ST_READ: begin
        res_d.grid_idx  = rd_cell;
        res_d.count     = rd_ent.count;
        res_d.last_cell = ((cursor_q + UsedW'(1)) == used_q);
        if (colors_q) begin
          for (int c = 0; c < 3; c++) begin
            case (pool_e'(mode_q))
              POOL_AVG: res_d.color[c] = quot[c];
              POOL_MIN: res_d.color[c] = SUM_W'(rd_ent.minc[c]);
              POOL_MAX: res_d.color[c] = SUM_W'(rd_ent.maxc[c]);
              POOL_SUM: res_d.color[c] = rd_ent.sum[c];
              default:  res_d.color[c] = '0;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) res_q <= res_d;
  end

  // output register
  logic    out_valid_q;
  result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // status to the controller
  always_comb begin
    stat_o.action     = action_q;
    stat_o.axis_last  = (axis_q == 2'd2);
    stat_o.oor        = oor_q;
    stat_o.srch_end   = (addr_q == used_q);
    stat_o.key_match  = (rd_key == key_cur);
    stat_o.count_sat  = (rd_ent.count == COUNT_MAX);
    stat_o.table_full = (used_q == UsedW'(TableDepth));
    stat_o.cur_empty  = (cursor_q >= used_q);
    stat_o.need_div   = colors_q && (mode_q == POOL_AVG);
    stat_o.div_done   = div_done;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // table invariants
  `VCP_ASSERT_IMPL(a_used_bound, clk_i, rst_ni, 1'b1, used_q <= UsedW'(TableDepth))
  `VCP_ASSERT_IMPL(a_cursor_bound, clk_i, rst_ni, 1'b1, cursor_q <= used_q)
  `VCP_ASSERT_NEXT(a_append_grows, clk_i, rst_ni, cmd_i.write_new, used_q == $past(used_q) + UsedW'(1))

endmodule

// ----- design/vcp_ctrl.sv -----
// ----------------------------------------------------------------------------
// vcp_ctrl
// Sequencer for add, read and clear transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vcp_ctrl import vcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (action_e'(stat_i.action))
          ACT_ADD:  state_d = S_MUL;
          ACT_READ: state_d = S_RD_CHK;
          ACT_CLEAR: begin
            cmd_o.clear      = 1'b1;
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_CLEARED;
            state_d          = S_DONE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_FIX;
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = stat_i.axis_last ? S_RANGE : S_MUL;
      end
      S_RANGE: begin
        if (stat_i.oor) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_RANGE;
          state_d          = S_DONE;
        end else begin
          cmd_o.srch_start = 1'b1;
          state_d          = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (stat_i.srch_end) begin
          state_d = S_UPD_NEW;
        end else begin
          cmd_o.mem_rd_srch = 1'b1;
          state_d           = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (stat_i.key_match) begin
          state_d = S_UPD_HIT;
        end else begin
          cmd_o.addr_inc = 1'b1;
          state_d        = S_SRCH_RD;
        end
      end
      S_UPD_HIT: begin
        cmd_o.res_set = 1'b1;
        if (stat_i.count_sat) begin
          cmd_o.res_status = ST_SATURATED;
        end else begin
          cmd_o.write_hit  = 1'b1;
          cmd_o.res_hit    = 1'b1;
          cmd_o.res_status = ST_ADDED;
        end
        state_d = S_DONE;
      end
      S_UPD_NEW: begin
        cmd_o.res_set = 1'b1;
        if (stat_i.table_full) begin
          cmd_o.res_status = ST_FULL;
        end else begin
          cmd_o.write_new  = 1'b1;
          cmd_o.res_status = ST_ADDED;
        end
        state_d = S_DONE;
      end
      S_RD_CHK: begin
        if (stat_i.cur_empty) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_EMPTY;
          state_d          = S_DONE;
        end else begin
          cmd_o.mem_rd_cur = 1'b1;
          state_d          = S_RD_WAIT;
        end
      end
      S_RD_WAIT: begin
        if (stat_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIVIDE;
        end else begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_READ;
          state_d          = S_DONE;
        end
      end
      S_DIVIDE: begin
        if (stat_i.div_done) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_READ;
          state_d          = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- design/voxel_color_pooling_table_unit.sv -----
// ----------------------------------------------------------------------------
// voxel_color_pooling_table_unit
// Voxel grid downsampler for colored points. One transaction at a time: an
// add scans the stored voxels with a linear key search (one memory read and
// one compare per voxel), after one shared 32x32 multiply per axis. A read
// in average mode waits for a bit-serial divider that produces the 24-bit
// quotients. The result sits in an output register, so the next transaction
// is taken while it waits. Unknown action codes are consumed with no result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_color_pooling_table_unit import vcp_pkg::*; #(
  parameter int TableDepth = DEFAULT_TABLE_DEPTH,
  parameter int IndexBits  = DEFAULT_INDEX_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                action_i,
  input  logic signed [COORD_W-1:0] pos_x_i,
  input  logic signed [COORD_W-1:0] pos_y_i,
  input  logic signed [COORD_W-1:0] pos_z_i,
  input  logic [COLOR_W-1:0]        red_in_i,
  input  logic [COLOR_W-1:0]        green_in_i,
  input  logic [COLOR_W-1:0]        blue_in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                status_o,
  output logic signed [CELL_W-1:0]  cell_x_o,
  output logic signed [CELL_W-1:0]  cell_y_o,
  output logic signed [CELL_W-1:0]  cell_z_o,
  output logic [SUM_W-1:0]          red_out_o,
  output logic [SUM_W-1:0]          green_out_o,
  output logic [SUM_W-1:0]          blue_out_o,
  output logic [COUNT_W-1:0]        points_in_cell_o,
  output logic                      final_cell_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  result_t   res;

  // controller
  vcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath
  vcp_datapath #(
    .TableDepth (TableDepth),
    .IndexBits  (IndexBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .action_i    (action_i),
    .pos_i       ({pos_z_i, pos_y_i, pos_x_i}),
    .rgb_i       ({blue_in_i, green_in_i, red_in_i}),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  // result fields
  assign status_o         = res.status;
  assign cell_x_o         = res.grid_idx[0];
  assign cell_y_o         = res.grid_idx[1];
  assign cell_z_o         = res.grid_idx[2];
  assign red_out_o        = res.color[0];
  assign green_out_o      = res.color[1];
  assign blue_out_o       = res.color[2];
  assign points_in_cell_o = res.count;
  assign final_cell_o     = res.last_cell;

endmodule
